@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER_CLK(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER_CLK(label, clk, rst_n, expr, msg)
`endif

`endif

@@ src/rahfd_pkg.sv @@
// ----------------------------------------------------------------------------
// rahfd_pkg
// Types, constants and helper functions of the RFID ASCII hex frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rahfd_pkg;

  // Number of ASCII digits in one frame (4 to 16).
  localparam int unsigned DIGITS_PER_FRAME = 12;
  localparam logic [3:0]  LAST_DIGIT       = 4'(DIGITS_PER_FRAME - 1);
  // Index of the byte that carries the reader's checksum.
  localparam logic [2:0]  CHK_INDEX        = 3'(DIGITS_PER_FRAME / 2 - 1);

  localparam logic [7:0] BYTE_HDR = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;

  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_F = 8'h46;

  localparam int unsigned TAG_W   = 40;
  localparam int unsigned SHIFT_W = 48;

  // Depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    STATUS_GOOD     = 2'd0,
    STATUS_MISMATCH = 2'd1,
    STATUS_ABORT    = 2'd2
  } frame_status_e;

  // Classified word passed from front to back.
  typedef struct packed {
    logic       is_hdr;
    logic       is_ctrl;
    logic [7:0] value;
  } rahfd_item_t;

  // Decimal and upper-case hex digits become their nibble value; any other byte passes unchanged.
  function automatic logic [7:0] digit_value(input logic [7:0] b);
    logic [7:0] v;
    if (b >= CHAR_0 && b <= CHAR_9) begin
      v = b - CHAR_0;
    end else if (b >= CHAR_A && b <= CHAR_F) begin
      v = b - CHAR_A + 8'd10;
    end else begin
      v = b;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ src/rfid_ascii_hex_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// rfid_ascii_hex_frame_decoder
// Decodes ASCII hex frames of a serial RFID reader into tag, checksum, status.
// ----------------------------------------------------------------------------
// Usage: each word on the input channel is one byte from the reader's UART.
// A word is taken at a rising edge where in_valid_i is high and in_stall_o
// low. Outside a frame every byte but the header 0x02 is dropped. A frame
// holds twelve hex digits; at its last digit one result word appears on the
// output channel with the 40-bit tag, the checksum sent by the reader and a
// status (good, mismatch). A CR, LF, ETX or header byte inside a frame ends
// it at once with an abort result whose tag and checksum are zero.
// Throughput is one byte per cycle: the front classifies each byte and writes
// it into a two-word queue, the back takes one word per cycle from the queue
// unless a result waits on a stalled output. The byte that completes or aborts
// a frame passes the queue and then the result register before out_valid_o
// rises. Reset empties the queue, clears the result valid flag and leaves the
// decoder waiting for a header. While the receiver stalls, the result is held;
// bytes that make no result keep draining, and a byte that would make a result
// waits at the queue head, so in_stall_o rises only once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module rfid_ascii_hex_frame_decoder (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    rx_byte_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [39:0]        tag_code_o,
  output logic [7:0]         received_sum_o,
  output logic [1:0]         frame_status_o
);

  // Classified byte on its way into the queue, and the queue head.
  rahfd_pkg::rahfd_item_t push_item;
  rahfd_pkg::rahfd_item_t head_item;
  logic                   push;
  logic                   q_full;
  logic                   q_valid;
  logic                   pop;

  // Front: handshake on the input side and byte classification.
  rahfd_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (push_item)
  );

  // Queue: lets the front keep accepting while the back waits on the output.
  rahfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (head_item)
  );

  // Back: frame tracking, byte pairing, checksum and the output register.
  rahfd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (head_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .tag_code_o     (tag_code_o),
    .received_sum_o (received_sum_o),
    .frame_status_o (frame_status_o)
  );

endmodule

`default_nettype wire

@@ src/rahfd_front.sv @@
// ----------------------------------------------------------------------------
// rahfd_front
// Input side: accepts received bytes and classifies them into queue words.
// ----------------------------------------------------------------------------
`default_nettype none

module rahfd_front (
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            rx_byte_i,
  input  wire logic                  q_full_i,
  output logic                       push_o,
  output rahfd_pkg::rahfd_item_t     item_o
);

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o.is_hdr  = (rx_byte_i == rahfd_pkg::BYTE_HDR);
    item_o.is_ctrl = (rx_byte_i == rahfd_pkg::BYTE_HDR) ||
                     (rx_byte_i == rahfd_pkg::BYTE_ETX) ||
                     (rx_byte_i == rahfd_pkg::BYTE_LF)  ||
                     (rx_byte_i == rahfd_pkg::BYTE_CR);
    item_o.value   = rahfd_pkg::digit_value(rx_byte_i);
  end

endmodule

`default_nettype wire

@@ src/rahfd_queue.sv @@
// ----------------------------------------------------------------------------
// rahfd_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rahfd_queue (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire rahfd_pkg::rahfd_item_t item_i,
  output logic                        full_o,
  output logic                        valid_o,
  input  wire logic                   pop_i,
  output rahfd_pkg::rahfd_item_t      item_o
);

  rahfd_pkg::rahfd_item_t              entry_q [rahfd_pkg::QUEUE_DEPTH];
  logic [rahfd_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [rahfd_pkg::QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [rahfd_pkg::QCNT_W-1:0]        count_q, count_d;
  logic                                do_push, do_pop;

  localparam logic [rahfd_pkg::QPTR_W-1:0] LastPtr =
    rahfd_pkg::QPTR_W'(rahfd_pkg::QUEUE_DEPTH - 1);
  localparam logic [rahfd_pkg::QCNT_W-1:0] FullCnt =
    rahfd_pkg::QCNT_W'(rahfd_pkg::QUEUE_DEPTH);

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

@@ src/rahfd_back.sv @@
// ----------------------------------------------------------------------------
// rahfd_back
// Frame state machine, byte assembly, checksum and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rahfd_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input  wire rahfd_pkg::rahfd_item_t        q_item_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [rahfd_pkg::TAG_W-1:0]        tag_code_o,
  output logic [7:0]                         received_sum_o,
  output logic [1:0]                         frame_status_o
);

  logic                                in_frame_q, in_frame_d;
  logic [3:0]                          digit_count_q, digit_count_d;
  logic [3:0]                          first_nibble_q, first_nibble_d;
  logic [7:0]                          running_xor_q, running_xor_d;
  logic [rahfd_pkg::SHIFT_W-1:0]       code_shift_q, code_shift_d;

  logic                                out_valid_q, out_valid_d;
  logic [rahfd_pkg::TAG_W-1:0]         tag_q, tag_d;
  logic [7:0]                          sum_q, sum_d;
  rahfd_pkg::frame_status_e            status_q, status_d;

  logic                                has_result;
  logic                                slot_free;
  logic [7:0]                          byte_val;
  logic [rahfd_pkg::SHIFT_W-1:0]       shift_new;
  logic [7:0]                          xor_new;

  // A word yields a result when it ends or aborts an open frame.
  assign has_result = in_frame_q &&
                      (q_item_i.is_ctrl || (digit_count_q == rahfd_pkg::LAST_DIGIT));
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign pop_o      = q_valid_i && (!has_result || slot_free);

  always_comb begin
    byte_val  = q_item_i.value | {first_nibble_q, 4'b0000};
    shift_new = code_shift_q;
    xor_new   = running_xor_q;
    if (digit_count_q[0]) begin
      shift_new = {code_shift_q[rahfd_pkg::SHIFT_W-9:0], byte_val};
      if (digit_count_q[3:1] != rahfd_pkg::CHK_INDEX) begin
        xor_new = running_xor_q ^ byte_val;
      end
    end
  end

  always_comb begin
    in_frame_d     = in_frame_q;
    digit_count_d  = digit_count_q;
    first_nibble_d = first_nibble_q;
    running_xor_d  = running_xor_q;
    code_shift_d   = code_shift_q;
    out_valid_d    = out_valid_q && out_stall_i;
    tag_d          = tag_q;
    sum_d          = sum_q;
    status_d       = status_q;

    if (pop_o) begin
      if (!in_frame_q) begin
        if (q_item_i.is_hdr) begin
          in_frame_d     = 1'b1;
          digit_count_d  = '0;
          first_nibble_d = '0;
          running_xor_d  = '0;
          code_shift_d   = '0;
        end
      end else if (q_item_i.is_ctrl) begin
        in_frame_d     = 1'b0;
        digit_count_d  = '0;
        first_nibble_d = '0;
        running_xor_d  = '0;
        code_shift_d   = '0;
        out_valid_d    = 1'b1;
        tag_d          = '0;
        sum_d          = '0;
        status_d       = rahfd_pkg::STATUS_ABORT;
      end else begin
        code_shift_d  = shift_new;
        running_xor_d = xor_new;
        if (!digit_count_q[0]) begin
          first_nibble_d = q_item_i.value[3:0];
        end
        if (digit_count_q == rahfd_pkg::LAST_DIGIT) begin
          out_valid_d    = 1'b1;
          tag_d          = shift_new[rahfd_pkg::SHIFT_W-1:8];
          sum_d          = shift_new[7:0];
          status_d       = (shift_new[7:0] == xor_new) ? rahfd_pkg::STATUS_GOOD
                                                       : rahfd_pkg::STATUS_MISMATCH;
          in_frame_d     = 1'b0;
          digit_count_d  = '0;
          first_nibble_d = '0;
          running_xor_d  = '0;
          code_shift_d   = '0;
        end else begin
          digit_count_d = digit_count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q     <= 1'b0;
      digit_count_q  <= '0;
      first_nibble_q <= '0;
      running_xor_q  <= '0;
      code_shift_q   <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      in_frame_q     <= in_frame_d;
      digit_count_q  <= digit_count_d;
      first_nibble_q <= first_nibble_d;
      running_xor_q  <= running_xor_d;
      code_shift_q   <= code_shift_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q    <= tag_d;
    sum_q    <= sum_d;
    status_q <= status_d;
  end

  assign out_valid_o    = out_valid_q;
  assign tag_code_o     = tag_q;
  assign received_sum_o = sum_q;
  assign frame_status_o = status_q;

  `ASSERT_NEVER_CLK(a_count_range, clk_i, rst_ni,
                    digit_count_q > rahfd_pkg::LAST_DIGIT, "digit count beyond frame length")
  `ASSERT_CLK(a_idle_clean, clk_i, rst_ni,
              !in_frame_q |-> (digit_count_q == '0 && running_xor_q == '0),
              "idle state not cleared")
  `ASSERT_CLK(a_result_loaded, clk_i, rst_ni, (pop_o && has_result) |=> out_valid_q,
              "result lost on its way to the output register")

endmodule

`default_nettype wire

@@ verif/rfid_ascii_hex_frame_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// rfid_ascii_hex_frame_decoder_tb
// Self-checking testbench of the RFID ASCII hex frame decoder: reader bytes
// go in one word at a time, and a local decoder model predicts every frame
// result, which is checked field by field as it leaves the block.
// ----------------------------------------------------------------------------
`default_nettype none

module rfid_ascii_hex_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // A quiet spell this long, with no word moving on either side, means a hang.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Cycles allowed after the last result for anything stray to show up.
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned PAIRS          = rahfd_pkg::DIGITS_PER_FRAME / 2;

  typedef struct packed {
    logic [39:0]              tag;
    logic [7:0]               sum;
    rahfd_pkg::frame_status_e status;
  } frame_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [39:0] tag_code_o;
  logic [7:0]  received_sum_o;
  logic [1:0]  frame_status_o;

  rfid_ascii_hex_frame_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .tag_code_o     (tag_code_o),
    .received_sum_o (received_sum_o),
    .frame_status_o (frame_status_o)
  );

  // Decoder model state, a copy of what the block should hold.
  logic        model_in_frame;
  logic [3:0]  model_digits;
  logic [3:0]  model_first;
  logic [7:0]  model_xor;
  logic [47:0] model_shift;

  frame_result_t expected_frames[$];

  bit          send_gaps_en;
  bit          recv_stall_en;
  int unsigned fail_count;
  int unsigned bytes_sent;
  int unsigned frame_bytes_sent;
  int unsigned good_seen;
  int unsigned mismatch_seen;
  int unsigned abort_seen;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Most gaps are short, a few are long, and many words follow back to back.
  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic bit is_control(input logic [7:0] b);
    return b == rahfd_pkg::BYTE_CR || b == rahfd_pkg::BYTE_LF ||
           b == rahfd_pkg::BYTE_ETX || b == rahfd_pkg::BYTE_HDR;
  endfunction

  // Upper-case hex digits give their nibble; everything else stays raw.
  function automatic logic [7:0] char_value(input logic [7:0] c);
    if (c >= rahfd_pkg::CHAR_0 && c <= rahfd_pkg::CHAR_9) return {4'h0, c[3:0]};
    if (c >= rahfd_pkg::CHAR_A && c <= rahfd_pkg::CHAR_F) return {4'h0, c[3:0]} + 8'd9;
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? rahfd_pkg::CHAR_0 + 8'(n) : rahfd_pkg::CHAR_A + 8'(n) - 8'd10;
  endfunction

  function automatic void model_clear();
    model_in_frame = 1'b0;
    model_digits   = '0;
    model_first    = '0;
    model_xor      = '0;
    model_shift    = '0;
  endfunction

  // Advances the decoder model by one accepted byte and queues any result.
  function automatic void decode_byte(input logic [7:0] b);
    frame_result_t r;
    logic [7:0]    v;
    logic [7:0]    pair;
    logic [3:0]    n;
    if (!model_in_frame) begin
      if (b == rahfd_pkg::BYTE_HDR) begin
        model_clear();
        model_in_frame = 1'b1;
      end
      return;
    end
    if (is_control(b)) begin
      model_clear();
      r = '{tag: '0, sum: '0, status: rahfd_pkg::STATUS_ABORT};
      expected_frames.push_back(r);
      return;
    end
    v = char_value(b);
    n = model_digits;
    if (n[0]) begin
      pair        = v | {model_first, 4'h0};
      model_shift = {model_shift[39:0], pair};
      // The checksum byte itself is kept out of the running XOR.
      if (n[3:1] != rahfd_pkg::CHK_INDEX) model_xor = model_xor ^ pair;
    end else begin
      model_first = v[3:0];
    end
    if (32'(n) + 1 >= rahfd_pkg::DIGITS_PER_FRAME) begin
      r.tag    = model_shift[47:8];
      r.sum    = model_shift[7:0];
      r.status = (model_shift[7:0] == model_xor) ? rahfd_pkg::STATUS_GOOD
                                                 : rahfd_pkg::STATUS_MISMATCH;
      expected_frames.push_back(r);
      model_clear();
    end else begin
      model_digits = n + 4'd1;
    end
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  // Offers one byte, holds it until the block takes it, then updates the model.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(send_gaps_en);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    if (model_in_frame || b == rahfd_pkg::BYTE_HDR) frame_bytes_sent++;
    decode_byte(b);
  endtask

  // A frame digit: mostly hex, sometimes lower case or any non-control byte.
  function automatic logic [7:0] pick_digit();
    int         r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 75) return hex_char(4'($urandom_range(0, 15)));
    if (r < 87) return 8'h61 + 8'($urandom_range(0, 5));
    do b = 8'($urandom_range(0, 255)); while (is_control(b));
    return b;
  endfunction

  function automatic logic [7:0] pick_control();
    case ($urandom_range(0, 3))
      0:       return rahfd_pkg::BYTE_CR;
      1:       return rahfd_pkg::BYTE_LF;
      2:       return rahfd_pkg::BYTE_ETX;
      default: return rahfd_pkg::BYTE_HDR;
    endcase
  endfunction

  // One frame of a random kind, followed now and then by trailing bytes.
  task automatic send_random_frame();
    logic [7:0] pairs [PAIRS];
    logic [7:0] sum;
    logic [7:0] noise;
    int         kind;
    int         cut;
    kind = $urandom_range(0, 99);
    send_byte(rahfd_pkg::BYTE_HDR);
    if (kind < 70) begin
      // Well-formed hex frame; a correct checksum unless a mismatch is wanted.
      sum = '0;
      for (int i = 0; i < PAIRS; i++) begin
        pairs[i] = 8'($urandom_range(0, 255));
        if (i != rahfd_pkg::CHK_INDEX) sum = sum ^ pairs[i];
      end
      pairs[rahfd_pkg::CHK_INDEX] = (kind < 50) ? sum : 8'($urandom_range(0, 255));
      for (int d = 0; d < rahfd_pkg::DIGITS_PER_FRAME; d++) begin
        if (d / 2 >= PAIRS) send_byte(pick_digit());
        else if (d % 2 == 0) send_byte(hex_char(pairs[d / 2][7:4]));
        else send_byte(hex_char(pairs[d / 2][3:0]));
      end
    end else if (kind < 85) begin
      repeat (rahfd_pkg::DIGITS_PER_FRAME) send_byte(pick_digit());
    end else begin
      // Broken frame: a control byte cuts it short.
      cut = $urandom_range(0, rahfd_pkg::DIGITS_PER_FRAME - 1);
      repeat (cut) send_byte(pick_digit());
      send_byte(pick_control());
    end
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      send_byte(rahfd_pkg::BYTE_CR);
      send_byte(rahfd_pkg::BYTE_LF);
    end else if (kind < 55) begin
      send_byte(rahfd_pkg::BYTE_ETX);
    end else if (kind < 70) begin
      repeat ($urandom_range(1, 3)) begin
        do noise = 8'($urandom_range(0, 255)); while (noise == rahfd_pkg::BYTE_HDR);
        send_byte(noise);
      end
    end
  endtask

  task automatic run_random_frames(input int unsigned target, input bit gaps,
                                   input bit stalls);
    int unsigned start;
    send_gaps_en  = gaps;
    recv_stall_en = stalls;
    start = frame_bytes_sent;
    while (frame_bytes_sent - start < target) send_random_frame();
  endtask

  // Idle noise, an all-ones good frame, and each way a frame can be aborted.
  task automatic test_directed_frames();
    send_gaps_en  = 1'b0;
    recv_stall_en = 1'b0;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(rahfd_pkg::BYTE_CR);
    send_byte(rahfd_pkg::BYTE_HDR);
    repeat (rahfd_pkg::DIGITS_PER_FRAME) send_byte(rahfd_pkg::CHAR_F);
    send_byte(rahfd_pkg::BYTE_HDR);
    send_byte(8'h61);
    send_byte(rahfd_pkg::BYTE_LF);
    send_byte(rahfd_pkg::BYTE_HDR);
    send_byte(rahfd_pkg::CHAR_0);
    send_byte(rahfd_pkg::BYTE_ETX);
    send_byte(rahfd_pkg::BYTE_HDR);
    send_byte(rahfd_pkg::BYTE_CR);
    // A header inside a frame aborts it and must not open a new one.
    send_byte(rahfd_pkg::BYTE_HDR);
    send_byte(rahfd_pkg::BYTE_HDR);
    send_byte(rahfd_pkg::CHAR_9);
    send_byte(rahfd_pkg::BYTE_ETX);
  endtask

  task automatic test_random_frames();
    run_random_frames(400, 1'b1, 1'b1);
  endtask

  // Back-to-back bytes against a stalling receiver fill the internal queue.
  task automatic test_input_backpressure();
    run_random_frames(130, 1'b0, 1'b1);
  endtask

  task automatic test_full_rate();
    run_random_frames(120, 1'b0, 1'b0);
  endtask

  initial begin : out_stall_drive
    int n;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      n = pick_gap(recv_stall_en);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    frame_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_frames.size() == 0) begin
        note_failure($sformatf("unexpected result: tag %h sum %h status %0d",
                               tag_code_o, received_sum_o, frame_status_o));
      end else begin
        want = expected_frames.pop_front();
        if (tag_code_o !== want.tag || received_sum_o !== want.sum ||
            frame_status_o !== want.status) begin
          note_failure($sformatf({"expected tag %h sum %h status %0d, ",
                                  "got tag %h sum %h status %0d"},
                                 want.tag, want.sum, want.status,
                                 tag_code_o, received_sum_o, frame_status_o));
        end
        case (want.status)
          rahfd_pkg::STATUS_GOOD:     good_seen++;
          rahfd_pkg::STATUS_MISMATCH: mismatch_seen++;
          default:                    abort_seen++;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_frames.size());
        $display("FAIL rfid_ascii_hex_frame_decoder");
        $finish;
      end
    end
  end

  initial begin
    model_clear();
    send_gaps_en  = 1'b0;
    recv_stall_en = 1'b0;
    in_valid_i <= 1'b0;
    rx_byte_i  <= '0;
    rst_ni     <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_frames();
    test_random_frames();
    test_input_backpressure();
    test_full_rate();

    in_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes, %0d of them inside frames or as headers.",
             bytes_sent, frame_bytes_sent);
    $display("Checked %0d good, %0d mismatched and %0d aborted frames; %0d failures.",
             good_seen, mismatch_seen, abort_seen, fail_count);
    if (fail_count == 0) begin
      $display("PASS rfid_ascii_hex_frame_decoder");
    end else begin
      $display("FAIL rfid_ascii_hex_frame_decoder");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+src
src/rahfd_pkg.sv
src/rahfd_front.sv
src/rahfd_queue.sv
src/rahfd_back.sv
src/rfid_ascii_hex_frame_decoder.sv
verif/rfid_ascii_hex_frame_decoder_tb.sv
